### hw/rtl/fsvf_pkg.sv
// package: kind codes, control word format and microprogram for the field serializer
`timescale 1ns / 1ps

package fsvf_pkg;

	localparam int KIND_W = 4;
	localparam int VAL_W  = 64;
	localparam int BYTE_W = 8;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t K_RAW     = 4'd0;
	localparam kind_t K_VU16    = 4'd1;
	localparam kind_t K_VS16    = 4'd2;
	localparam kind_t K_VU32    = 4'd3;
	localparam kind_t K_VS32    = 4'd4;
	localparam kind_t K_VU64    = 4'd5;
	localparam kind_t K_VS64    = 4'd6;
	localparam kind_t K_FIX32   = 4'd7;
	localparam kind_t K_SFIX32  = 4'd8;
	localparam kind_t K_FIX64   = 4'd9;
	localparam kind_t K_SFIX64  = 4'd10;

	// varint group size and continuation flag
	localparam int          GRP_W     = 7;
	localparam logic [7:0]  CONT_FLAG = 8'h80;

	// byte counts minus one for the fixed forms
	localparam logic [2:0] FIX32_LAST = 3'd3;
	localparam logic [2:0] FIX64_LAST = 3'd7;

	typedef logic [1:0] step_t;

	localparam step_t STEP_IDLE = 2'd0;
	localparam step_t STEP_RAW  = 2'd1;
	localparam step_t STEP_VAR  = 2'd2;
	localparam step_t STEP_FIX  = 2'd3;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_RAW,
		EMIT_VAR,
		EMIT_FIX
	} emit_t;

	typedef enum logic [1:0] {
		JMP_DISPATCH,
		JMP_IDLE,
		JMP_IF_MORE,
		JMP_IF_CNT
	} jmp_t;

	typedef struct packed {
		emit_t emit;
		jmp_t  jmp;
		step_t target;
	} ctrl_t;

	// microprogram rom
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t cw;
		cw = '{emit: EMIT_NONE, jmp: JMP_DISPATCH, target: STEP_IDLE};
		case (step)
			STEP_IDLE: cw = '{emit: EMIT_NONE, jmp: JMP_DISPATCH, target: STEP_IDLE};
			STEP_RAW:  cw = '{emit: EMIT_RAW,  jmp: JMP_IDLE,     target: STEP_IDLE};
			STEP_VAR:  cw = '{emit: EMIT_VAR,  jmp: JMP_IF_MORE,  target: STEP_VAR};
			STEP_FIX:  cw = '{emit: EMIT_FIX,  jmp: JMP_IF_CNT,   target: STEP_FIX};
			default:   cw = '{emit: EMIT_NONE, jmp: JMP_IDLE,     target: STEP_IDLE};
		endcase
		return cw;
	endfunction

	// dispatch table: entry step for each kind code, idle for unused codes
	function automatic step_t dispatch(input kind_t kind);
		step_t s;
		case (kind) inside
			K_RAW:                        s = STEP_RAW;
			[K_VU16:K_VS64]:              s = STEP_VAR;
			[K_FIX32:K_SFIX64]:           s = STEP_FIX;
			default:                      s = STEP_IDLE;
		endcase
		return s;
	endfunction

endpackage

### hw/rtl/field_serializer_varint_fixed_core.sv
// top level: microcoded field serializer for raw byte, varint, zigzag and fixed encodings
`timescale 1ns / 1ps

//  channel | signals                    | handshake
//  --------+----------------------------+--------------------------------------
//  input   | kind, value_bits           | taken at an edge with start && !busy
//  result  | out_byte, last             | one cycle, marked by strobe, no stall
//
// an item emits n bytes, n being its byte count (1 to 10); the rom steps
// once per cycle and each emitting step produces one output byte, shifting
// the value register for the varint and fixed forms
// busy stays high until the step that emits the last byte has executed;
// the next item can be taken in the cycle its predecessor's last byte shows
// reset returns the step counter to idle and clears the strobe
// unused kind codes are taken and produce no result

module field_serializer_varint_fixed_core
	import fsvf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [3:0]        kind,
	input  logic [63:0]       value_bits,
	output logic              strobe,
	output logic [7:0]        out_byte,
	output logic              last
);

	// sequencer state
	step_t             step_q;
	step_t             step_nxt;
	ctrl_t             cw;

	// datapath
	logic [VAL_W-1:0]  val_q;
	logic [VAL_W-1:0]  val_nxt;
	logic [VAL_W-1:0]  load_val;
	logic [2:0]        cnt_q;
	logic [2:0]        load_cnt;
	logic              accept;
	logic              more;

	// result register
	logic              strobe_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              emit_v;
	logic [BYTE_W-1:0] emit_byte;
	logic              emit_last;

	// zigzag forms at each width
	logic [15:0]       zz16;
	logic [31:0]       zz32;
	logic [63:0]       zz64;

	assign busy   = (step_q != STEP_IDLE);
	assign accept = start && !busy;
	assign cw     = ucode(step_q);

	// more groups left after the current varint byte
	assign more = (val_q[VAL_W-1:GRP_W] != '0);

	assign zz16 = {value_bits[14:0], 1'b0} ^ {16{value_bits[15]}};
	assign zz32 = {value_bits[30:0], 1'b0} ^ {32{value_bits[31]}};
	assign zz64 = {value_bits[62:0], 1'b0} ^ {64{value_bits[63]}};

	// value prepared at load: varints right aligned, fixed forms left aligned
	always_comb begin
		load_val = value_bits;
		load_cnt = FIX64_LAST;
		case (kind)
			K_RAW:    load_val = {56'd0, value_bits[7:0]};
			K_VU16:   load_val = {48'd0, value_bits[15:0]};
			K_VS16:   load_val = {48'd0, zz16};
			K_VU32:   load_val = {32'd0, value_bits[31:0]};
			K_VS32:   load_val = {32'd0, zz32};
			K_VU64:   load_val = value_bits;
			K_VS64:   load_val = zz64;
			K_FIX32: begin
				load_val = {value_bits[31:0], 32'd0};
				load_cnt = FIX32_LAST;
			end
			K_SFIX32: begin
				load_val = {zz32, 32'd0};
				load_cnt = FIX32_LAST;
			end
			K_FIX64:  load_val = value_bits;
			K_SFIX64: load_val = zz64;
			default:  load_val = value_bits;
		endcase
	end

	// control word decode: next step, emitted byte, value shift
	always_comb begin
		step_nxt  = STEP_IDLE;
		val_nxt   = val_q;
		emit_v    = 1'b0;
		emit_byte = '0;
		emit_last = 1'b0;

		case (cw.jmp)
			JMP_DISPATCH: step_nxt = accept ? dispatch(kind) : cw.target;
			JMP_IDLE:     step_nxt = STEP_IDLE;
			JMP_IF_MORE:  step_nxt = more ? cw.target : STEP_IDLE;
			JMP_IF_CNT:   step_nxt = (cnt_q != '0) ? cw.target : STEP_IDLE;
			default:      step_nxt = STEP_IDLE;
		endcase

		case (cw.emit)
			EMIT_RAW: begin
				emit_v    = 1'b1;
				emit_byte = val_q[BYTE_W-1:0];
				emit_last = 1'b1;
			end
			EMIT_VAR: begin
				emit_v    = 1'b1;
				emit_byte = {1'b0, val_q[GRP_W-1:0]} | (more ? CONT_FLAG : 8'h00);
				emit_last = !more;
				val_nxt   = val_q >> GRP_W;
			end
			EMIT_FIX: begin
				emit_v    = 1'b1;
				emit_byte = val_q[VAL_W-1 -: BYTE_W];
				emit_last = (cnt_q == '0);
				val_nxt   = val_q << BYTE_W;
			end
			default: begin
				emit_v = 1'b0;
			end
		endcase

		if (accept) begin
			val_nxt = load_val;
		end
	end

	// step counter and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_IDLE;
			strobe_q <= 1'b0;
		end else begin
			step_q   <= step_nxt;
			strobe_q <= emit_v;
		end
	end

	// value shifter, byte counter and result payload
	always_ff @(posedge clk) begin
		val_q <= val_nxt;
		if (accept) begin
			cnt_q <= load_cnt;
		end else if (cw.emit == EMIT_FIX) begin
			cnt_q <= cnt_q - 3'd1;
		end
		if (emit_v) begin
			byte_q <= emit_byte;
			last_q <= emit_last;
		end
	end

	assign strobe   = strobe_q;
	assign out_byte = byte_q;
	assign last     = last_q;

endmodule
